// ===== design/sv39_pkg.sv =====
// ----------------------------------------------------------------------------
// sv39_pkg
// shared types and constants for the sv39 page table map/translate core
// ----------------------------------------------------------------------------
package sv39_pkg;

  localparam int unsigned POOL_PAGES   = 16;
  localparam int unsigned ENTRIES      = 512;
  localparam int unsigned PAGE_W       = 13;
  localparam int unsigned STORE_DEPTH  = POOL_PAGES * ENTRIES;
  localparam int unsigned STORE_AW     = $clog2(STORE_DEPTH);
  localparam int unsigned POOL_IDX_W   = $clog2(POOL_PAGES);
  localparam int unsigned PTE_W        = 54;
  localparam int unsigned PPN_W        = 44;
  localparam int unsigned VA_W         = 39;
  localparam int unsigned PA_W         = 56;
  localparam int unsigned CNT_W        = 28;
  localparam int unsigned PERM_W       = 8;
  localparam int unsigned IDX_W        = 9;
  localparam int unsigned OFF_W        = 12;
  localparam int unsigned PPN_SHIFT    = 10;
  localparam logic [PPN_W-1:0] POOL_BASE_RST = PPN_W'(524288);

  typedef enum logic [0:0] {
    CMD_MAP       = 1'b0,
    CMD_TRANSLATE = 1'b1
  } cmd_t;

  typedef enum logic [0:0] {
    ST_OK        = 1'b0,
    ST_EXHAUSTED = 1'b1
  } status_t;

endpackage

// ===== design/sv39_in_if.sv =====
// ----------------------------------------------------------------------------
// sv39_in_if
// input word channel: command, addresses, count and permissions
// ----------------------------------------------------------------------------
interface sv39_in_if import sv39_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [0:0]        cmd;
  logic [VA_W-1:0]   virt_addr;
  logic [PA_W-1:0]   phys_addr;
  logic [CNT_W-1:0]  page_count;
  logic [PERM_W-1:0] perm_bits;

  modport source (output valid, cmd, virt_addr, phys_addr, page_count, perm_bits,
                  input ready);
  modport sink   (input valid, cmd, virt_addr, phys_addr, page_count, perm_bits,
                  output ready);
endinterface

// ===== design/sv39_out_if.sv =====
// ----------------------------------------------------------------------------
// sv39_out_if
// result word channel: translated address and status
// ----------------------------------------------------------------------------
interface sv39_out_if import sv39_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [PA_W-1:0] phys_addr_out;
  logic [0:0]      status;

  modport source (output valid, phys_addr_out, status, input ready);
  modport sink   (input valid, phys_addr_out, status, output ready);
endinterface

// ===== design/sv39_ram.sv =====
// ----------------------------------------------------------------------------
// sv39_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module sv39_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== design/sv39_page_table_map_translate_core.sv =====
// ----------------------------------------------------------------------------
// sv39_page_table_map_translate_core
// builds and walks a three level sv39 page table held in a local table ram
// ----------------------------------------------------------------------------
// sequence: a translate walks each of the three levels with one ram read state and one
//   decide/write state per level, allocation adding none; a map walks the levels for each
//   page and then writes the leaf; a zero count map goes straight to the done state
// flow: one item at a time; the result waits in an output
//   register so the next word is taken while it is pending
// reset: after rst_n the table ram is cleared one entry a cycle
//   (all STORE_DEPTH = 8192 entries) before the first word is taken
module sv39_page_table_map_translate_core import sv39_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [PPN_W-1:0]  cfg_wdata,
  sv39_in_if.sink           in_ch,
  sv39_out_if.source        out_ch
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_DECIDE, S_LEAF, S_DONE
  } state_t;

  state_t              state_r;
  logic [STORE_AW-1:0] clr_addr_r;
  logic [PPN_W-1:0]    pool_base_r;
  logic [PAGE_W-1:0]   next_free_r;
  logic [1:0]          lvl_r;
  logic [POOL_IDX_W-1:0] page_r;
  logic                cmd_r;
  logic [VA_W-1:0]     va_r;
  logic [PA_W-1:0]     pa_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [PERM_W-1:0]   perm_r;
  logic [PA_W-1:0]     res_pa_r;
  logic                res_st_r;
  logic [PA_W-1:0]     out_pa_r;
  logic                out_st_r;
  logic                out_valid_r;
  logic                out_valid_nxt;

  logic                ram_we;
  logic [STORE_AW-1:0] ram_addr;
  logic [PTE_W-1:0]    ram_wdata;
  logic [PTE_W-1:0]    ram_rdata;

  logic [IDX_W-1:0]    vidx;
  logic [STORE_AW-1:0] walk_addr;
  logic [PPN_W-1:0]    rel;
  logic [PPN_W-1:0]    new_ppn;

  always_comb begin
    case (lvl_r)
      2'd0:    vidx = va_r[OFF_W+2*IDX_W +: IDX_W];
      2'd1:    vidx = va_r[OFF_W+IDX_W +: IDX_W];
      default: vidx = va_r[OFF_W +: IDX_W];
    endcase
  end

  assign walk_addr = {page_r, vidx};
  assign rel       = ram_rdata[PPN_SHIFT +: PPN_W] - pool_base_r;
  assign new_ppn   = pool_base_r + PPN_W'(next_free_r);

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = walk_addr;
    ram_wdata = '0;
    case (state_r)
      S_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_addr_r;
      end
      S_DECIDE: begin
        // allocate a missing intermediate table
        if (lvl_r != 2'd2 && !ram_rdata[0] && next_free_r < PAGE_W'(POOL_PAGES)) begin
          ram_we    = 1'b1;
          ram_wdata = PTE_W'({new_ppn, {PPN_SHIFT-1{1'b0}}, 1'b1});
        end
      end
      S_LEAF: begin
        ram_we    = 1'b1;
        ram_wdata = PTE_W'({pa_r[PA_W-1:OFF_W], {PPN_SHIFT{1'b0}}}) |
                    PTE_W'(perm_r) | PTE_W'(1);
      end
      default: ;
    endcase
  end

  sv39_ram #(.WIDTH(PTE_W), .DEPTH(STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // pending word drops when taken, a finished item loads a new one
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (state_r == S_DONE && (!out_valid_r || out_ch.ready)) out_valid_nxt = 1'b1;
  end

  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.phys_addr_out = out_pa_r;
  assign out_ch.status        = out_st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      pool_base_r <= POOL_BASE_RST;
      next_free_r <= PAGE_W'(1);
      out_valid_r <= 1'b0;
      lvl_r       <= '0;
      page_r      <= '0;
    end else begin
      if (cfg_we) pool_base_r <= cfg_wdata;
      out_valid_r <= out_valid_nxt;
      case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + STORE_AW'(1);
          if (clr_addr_r == STORE_AW'(STORE_DEPTH-1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_ch.valid) begin
            cmd_r  <= in_ch.cmd;
            va_r   <= (in_ch.cmd == CMD_TRANSLATE) ? in_ch.virt_addr
                      : {in_ch.virt_addr[VA_W-1:OFF_W], {OFF_W{1'b0}}};
            pa_r   <= in_ch.phys_addr;
            cnt_r  <= in_ch.page_count;
            perm_r <= in_ch.perm_bits;
            lvl_r  <= '0;
            page_r <= '0;
            res_pa_r <= '0;
            res_st_r <= ST_OK;
            if (in_ch.cmd == CMD_MAP && in_ch.page_count == '0) state_r <= S_DONE;
            else state_r <= S_READ;
          end
        end
        S_READ: state_r <= S_DECIDE;
        S_DECIDE: begin
          if (lvl_r == 2'd2) begin
            // ram_rdata is the leaf
            if (cmd_r == CMD_TRANSLATE) begin
              res_pa_r <= {ram_rdata[PPN_SHIFT +: PPN_W], va_r[OFF_W-1:0]};
              state_r  <= S_DONE;
            end else begin
              state_r <= S_LEAF;
            end
          end else if (ram_rdata[0]) begin
            if (rel >= PPN_W'(POOL_PAGES)) begin
              res_st_r <= ST_EXHAUSTED;
              state_r  <= S_DONE;
            end else begin
              page_r  <= rel[POOL_IDX_W-1:0];
              lvl_r   <= lvl_r + 2'd1;
              state_r <= S_READ;
            end
          end else if (next_free_r >= PAGE_W'(POOL_PAGES)) begin
            res_st_r <= ST_EXHAUSTED;
            state_r  <= S_DONE;
          end else begin
            page_r      <= next_free_r[POOL_IDX_W-1:0];
            next_free_r <= next_free_r + PAGE_W'(1);
            lvl_r       <= lvl_r + 2'd1;
            state_r     <= S_READ;
          end
        end
        S_LEAF: begin
          va_r   <= va_r + VA_W'(1 << OFF_W);
          pa_r   <= pa_r + PA_W'(1 << OFF_W);
          cnt_r  <= cnt_r - CNT_W'(1);
          lvl_r  <= '0;
          page_r <= '0;
          if (cnt_r == CNT_W'(1)) state_r <= S_DONE;
          else state_r <= S_READ;
        end
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_pa_r <= res_pa_r;
            out_st_r <= res_st_r;
            state_r  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // a result word is never overwritten while it waits
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r && $stable(out_pa_r))
    else $error("pending result lost");

  // the free pointer never passes the pool size
  assert property (@(posedge clk) disable iff (!rst_n)
    next_free_r <= PAGE_W'(POOL_PAGES))
    else $error("pool pointer overflow");

  // the table ram is only written during clear, allocation or leaf update
  assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_CLEAR || state_r == S_DECIDE || state_r == S_LEAF))
    else $error("stray table write");

endmodule
